// ===== rtl/dlle_pkg.sv =====
package dlle_pkg;

    localparam int NODES      = 64;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_W     = $clog2(NODES);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int CNT_W      = $clog2(NODES + 1);

    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NODES);

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_REMOVE     = 3'd4;
    localparam logic [2:0] REQ_READ_POS   = 3'd5;
    localparam logic [2:0] REQ_CLEAR      = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NULL      = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
    localparam logic [2:0] ST_BAD_POS   = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] value;
        logic [5:0]  handle;
        logic [5:0]  position;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_value;
        logic [5:0]  new_handle;
        logic [6:0]  count;
        logic [31:0] front_value;
        logic [31:0] back_value;
    } t_out;

    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] slot;
    } t_alloc;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_RM_RD,
        S_RM_WR,
        S_RM_VAL,
        S_WALK_RD,
        S_WALK_DT,
        S_VAL_DT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/dlle_ram.sv =====
module dlle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/dlle_alloc.sv =====
module dlle_alloc (
    input  logic [dlle_pkg::NODES-1:0] i_used,
    output dlle_pkg::t_alloc           o_alloc
);

    // lowest free slot wins
    always_comb begin
        o_alloc.full = &i_used;
        o_alloc.slot = '0;
        for (int i = dlle_pkg::NODES - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                o_alloc.slot = dlle_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

// ===== rtl/doubly_linked_list_engine.sv =====
// Doubly linked list over a pool of 64 slots kept in three one-port-read RAMs
// (value, next link, prev link); head, tail, count, the used-slot map and the
// head and tail values sit in flip-flops. One request is handled at a time:
// push writes the new node and, when the list was not empty, then splices the
// old end; pop and remove read the links, rewrite the neighbors and, when an
// end moves, fetch the new end value; clear and refused requests go straight
// to the finish step, and read by position walks the next-link RAM from the
// head. The result is then handed to the output register. A new request is
// taken while the previous result still waits at the output. A push gets the
// lowest free slot as its handle; zero values are refused as null.
module doubly_linked_list_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dlle_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dlle_pkg::t_out o_out_data
);

    localparam int SW = dlle_pkg::SLOT_W;
    localparam int LW = dlle_pkg::LINK_W;
    localparam int VW = dlle_pkg::VALUE_BITS;
    localparam int CW = dlle_pkg::CNT_W;

    dlle_pkg::t_state         r_state, n_state;
    dlle_pkg::t_in            r_rq, n_rq;
    logic [dlle_pkg::NODES-1:0] r_used, n_used;
    logic [LW-1:0]            r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]            r_count, n_count;
    logic [VW-1:0]            r_front, n_front, r_back, n_back;
    logic [SW-1:0]            r_slot, n_slot, r_cur, n_cur;
    logic [5:0]               r_idx, n_idx;
    logic [2:0]               r_status, n_status;
    logic [VW-1:0]            r_res, n_res;
    logic [SW-1:0]            r_nh, n_nh;
    logic                     r_fix_front, n_fix_front;
    // old end slot for the splice after a push: old head on a front push,
    // old tail on a back push
    logic [SW-1:0]            r_old_end, n_old_end;
    dlle_pkg::t_out           r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    // RAM ports
    logic          val_we, nxt_we, prv_we;
    logic [SW-1:0] val_waddr, nxt_waddr, prv_waddr;
    logic [VW-1:0] val_wdata, val_rdata;
    logic [LW-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;
    logic [SW-1:0] val_raddr, nxt_raddr, prv_raddr;

    dlle_pkg::t_alloc alloc;

    dlle_alloc u_alloc (
        .i_used  (r_used),
        .o_alloc (alloc)
    );

    dlle_ram #(.WIDTH(VW), .DEPTH(dlle_pkg::NODES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    dlle_ram #(.WIDTH(LW), .DEPTH(dlle_pkg::NODES)) u_nxt_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (nxt_raddr),
        .o_rdata (nxt_rdata)
    );

    dlle_ram #(.WIDTH(LW), .DEPTH(dlle_pkg::NODES)) u_prv_ram (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_waddr),
        .i_wdata (prv_wdata),
        .i_raddr (prv_raddr),
        .o_rdata (prv_rdata)
    );

    assign o_in_ready  = (r_state == dlle_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlle_pkg::S_IDLE;
            r_used      <= '0;
            r_head      <= dlle_pkg::NONE_LINK;
            r_tail      <= dlle_pkg::NONE_LINK;
            r_count     <= '0;
            r_front     <= '0;
            r_back      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_front     <= n_front;
            r_back      <= n_back;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_rq        <= n_rq;
        r_slot      <= n_slot;
        r_cur       <= n_cur;
        r_idx       <= n_idx;
        r_status    <= n_status;
        r_res       <= n_res;
        r_nh        <= n_nh;
        r_fix_front <= n_fix_front;
        r_old_end   <= n_old_end;
        r_out       <= n_out;
    end

    always_comb begin
        logic [LW-1:0] p;
        logic [LW-1:0] n;
        logic [VW-1:0] v;

        p = prv_rdata;
        n = nxt_rdata;
        v = r_rq.value[VW-1:0];

        n_state     = r_state;
        n_rq        = r_rq;
        n_used      = r_used;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_slot      = r_slot;
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_status    = r_status;
        n_res       = r_res;
        n_nh        = r_nh;
        n_fix_front = r_fix_front;
        n_old_end   = r_old_end;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        val_we    = 1'b0;
        val_waddr = '0;
        val_wdata = '0;
        val_raddr = '0;
        nxt_we    = 1'b0;
        nxt_waddr = '0;
        nxt_wdata = '0;
        nxt_raddr = r_slot;
        prv_we    = 1'b0;
        prv_waddr = '0;
        prv_wdata = '0;
        prv_raddr = r_slot;

        unique case (r_state)
            dlle_pkg::S_IDLE: begin
                // take the request
                if (i_in_valid) begin
                    n_rq    = i_in_data;
                    n_state = dlle_pkg::S_EXEC;
                end
            end

            dlle_pkg::S_EXEC: begin
                n_status = dlle_pkg::ST_OK;
                n_res    = '0;
                n_nh     = '0;
                n_state  = dlle_pkg::S_DONE;
                case (r_rq.req_type) inside
                    dlle_pkg::REQ_PUSH_FRONT, dlle_pkg::REQ_PUSH_BACK: begin
                        if (v == '0) begin
                            n_status = dlle_pkg::ST_NULL;
                        end else if (alloc.full) begin
                            n_status = dlle_pkg::ST_FULL;
                        end else begin
                            // write the new node, splice the neighbor next cycle
                            val_we    = 1'b1;
                            val_waddr = alloc.slot;
                            val_wdata = v;
                            nxt_we    = 1'b1;
                            nxt_waddr = alloc.slot;
                            prv_we    = 1'b1;
                            prv_waddr = alloc.slot;
                            n_used[alloc.slot] = 1'b1;
                            n_count = r_count + 1'b1;
                            n_nh    = alloc.slot;
                            n_slot  = alloc.slot;
                            if (r_head == dlle_pkg::NONE_LINK) begin
                                nxt_wdata = dlle_pkg::NONE_LINK;
                                prv_wdata = dlle_pkg::NONE_LINK;
                                n_head  = LW'(alloc.slot);
                                n_tail  = LW'(alloc.slot);
                                n_front = v;
                                n_back  = v;
                            end else if (r_rq.req_type == dlle_pkg::REQ_PUSH_FRONT) begin
                                nxt_wdata = r_head;
                                prv_wdata = dlle_pkg::NONE_LINK;
                                n_old_end = r_head[SW-1:0];
                                n_head  = LW'(alloc.slot);
                                n_front = v;
                                n_state = dlle_pkg::S_LINK;
                            end else begin
                                nxt_wdata = dlle_pkg::NONE_LINK;
                                prv_wdata = r_tail;
                                n_old_end = r_tail[SW-1:0];
                                n_tail  = LW'(alloc.slot);
                                n_back  = v;
                                n_state = dlle_pkg::S_LINK;
                            end
                        end
                    end
                    dlle_pkg::REQ_POP_FRONT: begin
                        if (r_head != dlle_pkg::NONE_LINK) begin
                            n_slot  = r_head[SW-1:0];
                            n_res   = r_front;
                            n_state = dlle_pkg::S_RM_RD;
                        end
                    end
                    dlle_pkg::REQ_POP_BACK: begin
                        if (r_tail != dlle_pkg::NONE_LINK) begin
                            n_slot  = r_tail[SW-1:0];
                            n_res   = r_back;
                            n_state = dlle_pkg::S_RM_RD;
                        end
                    end
                    dlle_pkg::REQ_REMOVE: begin
                        if ((32'(r_rq.handle) < dlle_pkg::NODES) &&
                            r_used[SW'(r_rq.handle)]) begin
                            n_slot  = SW'(r_rq.handle);
                            n_state = dlle_pkg::S_RM_RD;
                        end else begin
                            n_status = dlle_pkg::ST_BAD_HANDLE;
                        end
                    end
                    dlle_pkg::REQ_READ_POS: begin
                        if (32'(r_rq.position) >= 32'(r_count)) begin
                            n_status = dlle_pkg::ST_BAD_POS;
                        end else begin
                            n_cur   = r_head[SW-1:0];
                            n_idx   = '0;
                            n_state = dlle_pkg::S_WALK_RD;
                        end
                    end
                    dlle_pkg::REQ_CLEAR: begin
                        n_used  = '0;
                        n_head  = dlle_pkg::NONE_LINK;
                        n_tail  = dlle_pkg::NONE_LINK;
                        n_count = '0;
                        n_front = '0;
                        n_back  = '0;
                    end
                    default: begin
                    end
                endcase
            end

            dlle_pkg::S_LINK: begin
                // point the old end at the new node
                if (r_rq.req_type == dlle_pkg::REQ_PUSH_FRONT) begin
                    prv_we    = 1'b1;
                    prv_waddr = r_old_end;
                    prv_wdata = LW'(r_slot);
                end else begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_old_end;
                    nxt_wdata = LW'(r_slot);
                end
                n_state = dlle_pkg::S_DONE;
            end

            dlle_pkg::S_RM_RD: begin
                // link RAM reads of r_slot are issued by default
                n_state = dlle_pkg::S_RM_WR;
            end

            dlle_pkg::S_RM_WR: begin
                if (p != dlle_pkg::NONE_LINK) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = p[SW-1:0];
                    nxt_wdata = n;
                end else begin
                    n_head = n;
                end
                if (n != dlle_pkg::NONE_LINK) begin
                    prv_we    = 1'b1;
                    prv_waddr = n[SW-1:0];
                    prv_wdata = p;
                end else begin
                    n_tail = p;
                end
                n_used[r_slot] = 1'b0;
                n_count = r_count - 1'b1;
                n_state = dlle_pkg::S_DONE;
                if (p == dlle_pkg::NONE_LINK && n == dlle_pkg::NONE_LINK) begin
                    n_front = '0;
                    n_back  = '0;
                end else if (p == dlle_pkg::NONE_LINK) begin
                    // new head: fetch its value
                    val_raddr   = n[SW-1:0];
                    n_fix_front = 1'b1;
                    n_state     = dlle_pkg::S_RM_VAL;
                end else if (n == dlle_pkg::NONE_LINK) begin
                    val_raddr   = p[SW-1:0];
                    n_fix_front = 1'b0;
                    n_state     = dlle_pkg::S_RM_VAL;
                end
            end

            dlle_pkg::S_RM_VAL: begin
                if (r_fix_front) begin
                    n_front = val_rdata;
                end else begin
                    n_back = val_rdata;
                end
                n_state = dlle_pkg::S_DONE;
            end

            dlle_pkg::S_WALK_RD: begin
                // at the target: read its value, else follow next
                nxt_raddr = r_cur;
                val_raddr = r_cur;
                if (r_idx == r_rq.position) begin
                    n_state = dlle_pkg::S_VAL_DT;
                end else begin
                    n_state = dlle_pkg::S_WALK_DT;
                end
            end

            dlle_pkg::S_WALK_DT: begin
                n_cur   = n[SW-1:0];
                n_idx   = r_idx + 1'b1;
                n_state = dlle_pkg::S_WALK_RD;
            end

            dlle_pkg::S_VAL_DT: begin
                n_res   = val_rdata;
                n_state = dlle_pkg::S_DONE;
            end

            dlle_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.status       = r_status;
                    n_out.result_value = 32'(r_res);
                    n_out.new_handle   = 6'(r_nh);
                    n_out.count        = 7'(r_count);
                    n_out.front_value  = 32'(r_front);
                    n_out.back_value   = 32'(r_back);
                    n_out_valid        = 1'b1;
                    n_state            = dlle_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = dlle_pkg::S_IDLE;
            end
        endcase
    end

    // count stays within the pool
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= dlle_pkg::NODES)
        else $error("element count beyond pool size");

    // empty list has no head and no tail
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == dlle_pkg::NONE_LINK) &&
        (r_count == '0) == (r_tail == dlle_pkg::NONE_LINK))
        else $error("head/tail disagree with count");

    // used map tracks the count
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == 32'(r_count))
        else $error("used-slot map disagrees with count");

    // a result appears only from the finish step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == dlle_pkg::S_DONE))
        else $error("result raised outside finish step");

endmodule
